// ===== rtl/core/rpvg_pkg.sv =====
`timescale 1ns / 1ps
package rpvg_pkg;

    // reciprocal of the cordic gain, unsigned q0.32
    localparam logic [31:0] INV_GAIN = 32'd2608131496;
    // saturation limit of the perimeter sum
    localparam logic [39:0] PERIM_MAX = 40'hFF_FFFF_FFFF;
    localparam logic [6:0] MIN_SIDES = 7'd3;

    // control handed from the back end to the shared cordic unit
    typedef struct packed {
        logic start;
        logic rotate;
    } crd_ctl_t;

    // arctangent of 2^-i in binary angle units, 2^32 per turn
    function automatic logic [31:0] atan_q32(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0: v = 32'd536870912;
            5'd1: v = 32'd316933406;
            5'd2: v = 32'd167458907;
            5'd3: v = 32'd85004756;
            5'd4: v = 32'd42667331;
            5'd5: v = 32'd21354465;
            5'd6: v = 32'd10679838;
            5'd7: v = 32'd5340245;
            5'd8: v = 32'd2670163;
            5'd9: v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/rpvg_fifo.sv =====
`timescale 1ns / 1ps
module rpvg_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_wr, do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // two entry request queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_wr) wr_ptr_reg <= ~wr_ptr_reg;
            if (do_rd) rd_ptr_reg <= ~rd_ptr_reg;
            if (do_wr && !do_rd) count_reg <= count_reg + 2'd1;
            else if (do_rd && !do_wr) count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== rtl/core/rpvg_front.sv =====
`timescale 1ns / 1ps
module rpvg_front #(
    parameter int CW        = 32,
    parameter int W         = 48,
    parameter int IN_W      = 136,
    parameter int MAX_SIDES = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,
    output logic                job_valid,
    input  logic                job_ready,
    output logic [CW-1:0]       job_cx,
    output logic [CW-1:0]       job_cy,
    output logic [W-1:0]        job_dx,
    output logic [W-1:0]        job_dy,
    output logic [6:0]          job_n,
    output logic [31:0]         job_step
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]          state_reg;
    logic [CW-1:0]       cx_reg, cy_reg;
    logic [W-1:0]        dx_reg, dy_reg;
    logic [6:0]          n_reg;
    logic [32:0]         dvd_reg, q_reg;
    logic [6:0]          rem_reg;
    logic [5:0]          cnt_reg;
    logic signed [W-1:0] cx_s, cy_s, vx_s, vy_s;
    logic [6:0]          sides, n_next;
    logic [7:0]          trial;

    assign cx_s  = W'(signed'(s_tdata[CW-1:0]));
    assign cy_s  = W'(signed'(s_tdata[2*CW-1:CW]));
    assign vx_s  = W'(signed'(s_tdata[3*CW-1:2*CW]));
    assign vy_s  = W'(signed'(s_tdata[4*CW-1:3*CW]));
    assign sides = s_tdata[4*CW+6:4*CW];

    // clamp the side count
    always_comb begin
        if (sides < rpvg_pkg::MIN_SIDES) n_next = rpvg_pkg::MIN_SIDES;
        else if (sides > 7'(MAX_SIDES)) n_next = 7'(MAX_SIDES);
        else n_next = sides;
    end

    assign trial     = {rem_reg, dvd_reg[32]};
    assign s_tready  = (state_reg == F_IDLE);
    assign job_valid = (state_reg == F_PUSH);
    assign job_cx    = cx_reg;
    assign job_cy    = cy_reg;
    assign job_dx    = dx_reg;
    assign job_dy    = dy_reg;
    assign job_n     = n_reg;
    assign job_step  = q_reg[31:0];

    // accept, then a restoring divide for the rounded step angle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (s_tvalid) begin
                        cx_reg    <= s_tdata[CW-1:0];
                        cy_reg    <= s_tdata[2*CW-1:CW];
                        dx_reg    <= vx_s - cx_s;
                        dy_reg    <= vy_s - cy_s;
                        n_reg     <= n_next;
                        dvd_reg   <= {1'b1, 26'd0, n_next[6:1]};
                        rem_reg   <= 7'd0;
                        q_reg     <= 33'd0;
                        cnt_reg   <= 6'd0;
                        state_reg <= F_DIV;
                    end
                end
                F_DIV: begin
                    if (trial >= {1'b0, n_reg}) begin
                        rem_reg <= 7'(trial - {1'b0, n_reg});
                        q_reg   <= {q_reg[31:0], 1'b1};
                    end else begin
                        rem_reg <= trial[6:0];
                        q_reg   <= {q_reg[31:0], 1'b0};
                    end
                    dvd_reg <= {dvd_reg[31:0], 1'b0};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd32) state_reg <= F_PUSH;
                end
                F_PUSH: begin
                    if (job_ready) state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/rpvg_cordic.sv =====
`timescale 1ns / 1ps
module rpvg_cordic #(
    parameter int W     = 48,
    parameter int STEPS = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rpvg_pkg::crd_ctl_t  ctl,
    input  logic signed [W-1:0] in_x,
    input  logic signed [W-1:0] in_y,
    input  logic [31:0]         in_ang,
    output logic                done,
    output logic signed [W-1:0] out_x,
    output logic signed [W-1:0] out_y
);

    localparam int IW = $clog2(STEPS);
    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_ITER = 3'd1;
    localparam logic [2:0] C_UX0  = 3'd2;
    localparam logic [2:0] C_UX1  = 3'd3;
    localparam logic [2:0] C_UY0  = 3'd4;
    localparam logic [2:0] C_UY1  = 3'd5;

    logic [2:0]          state_reg;
    logic                done_reg, rot_reg, neg_reg;
    logic [IW-1:0]       iter_reg;
    logic signed [W-1:0] x_reg, y_reg, ox_reg, oy_reg;
    logic signed [33:0]  z_reg;
    logic [63:0]         plo_reg;
    logic [W-33:0]       mhi_reg;
    logic signed [W-1:0] xs, ys, v, px, py;
    logic [W-1:0]        mabs, r;
    logic signed [33:0]  at, z0;
    logic [31:0]         qs, rr;
    logic [1:0]          q;
    logic                dpos;

    assign done  = done_reg;
    assign out_x = ox_reg;
    assign out_y = oy_reg;

    // quadrant fold of the start angle
    always_comb begin
        qs = in_ang + 32'h2000_0000;
        q  = qs[31:30];
        rr = in_ang - {q, 30'd0};
        z0 = 34'(signed'(rr));
        case (q)
            2'd1: begin px = -in_y; py = in_x; end
            2'd2: begin px = -in_x; py = -in_y; end
            2'd3: begin px = in_y; py = -in_x; end
            default: begin px = in_x; py = in_y; end
        endcase
    end

    // one micro-rotation
    assign xs   = x_reg >>> iter_reg;
    assign ys   = y_reg >>> iter_reg;
    assign at   = signed'({2'b00, rpvg_pkg::atan_q32(5'(iter_reg))});
    assign dpos = rot_reg ? !z_reg[33] : y_reg[W-1];

    // gain removal, split in a low and a high partial product
    assign v    = (state_reg == C_UX0) ? x_reg : y_reg;
    assign mabs = v[W-1] ? W'(-v) : W'(v);
    assign r    = W'(64'(mhi_reg) * 64'(rpvg_pkg::INV_GAIN))
                + W'((plo_reg + 64'h8000_0000) >> 32);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (state_reg == C_UY1);
            case (state_reg)
                C_IDLE: begin
                    if (ctl.start) begin
                        rot_reg  <= ctl.rotate;
                        iter_reg <= '0;
                        z_reg    <= z0;
                        if (ctl.rotate) begin
                            x_reg <= px;
                            y_reg <= py;
                        end else if (in_x[W-1]) begin
                            x_reg <= -in_x;
                            y_reg <= -in_y;
                        end else begin
                            x_reg <= in_x;
                            y_reg <= in_y;
                        end
                        state_reg <= C_ITER;
                    end
                end
                C_ITER: begin
                    if (dpos) begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - at;
                    end else begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + at;
                    end
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == IW'(STEPS - 1)) state_reg <= C_UX0;
                end
                C_UX0, C_UY0: begin
                    neg_reg   <= v[W-1];
                    plo_reg   <= 64'(mabs[31:0]) * 64'(rpvg_pkg::INV_GAIN);
                    mhi_reg   <= mabs[W-1:32];
                    state_reg <= (state_reg == C_UX0) ? C_UX1 : C_UY1;
                end
                C_UX1: begin
                    ox_reg    <= neg_reg ? -signed'(r) : signed'(r);
                    state_reg <= C_UY0;
                end
                C_UY1: begin
                    oy_reg    <= neg_reg ? -signed'(r) : signed'(r);
                    state_reg <= C_IDLE;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/rpvg_back.sv =====
`timescale 1ns / 1ps
module rpvg_back #(
    parameter int CW    = 32,
    parameter int W     = 48,
    parameter int OUT_W = 112,
    parameter int STEPS = 24
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             job_valid,
    output logic             job_ready,
    input  logic [CW-1:0]    job_cx,
    input  logic [CW-1:0]    job_cy,
    input  logic [W-1:0]     job_dx,
    input  logic [W-1:0]     job_dy,
    input  logic [6:0]       job_n,
    input  logic [31:0]      job_step,
    input  logic [30:0]      min_radius,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,
    output logic [0:0]       m_tuser,
    output logic             m_tlast
);

    localparam int SW = ((W > 40) ? W : 40) + 1;
    localparam logic signed [W-1:0] CMAX = {{(W-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = ~CMAX;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_MAG  = 3'd1;
    localparam logic [2:0] B_ROT  = 3'd2;
    localparam logic [2:0] B_EDGE = 3'd3;
    localparam logic [2:0] B_WRAP = 3'd4;
    localparam logic [2:0] B_EMIT = 3'd5;
    localparam logic [2:0] B_DEG  = 3'd6;

    logic [2:0]          state_reg;
    logic signed [W-1:0] cx_reg, cy_reg, dx_reg, dy_reg;
    logic signed [W-1:0] p0x_reg, p0y_reg, prvx_reg, prvy_reg, curx_reg, cury_reg;
    logic [6:0]          n_reg;
    logic [31:0]         step_reg, ang_reg;
    logic [5:0]          idx_reg;
    logic [39:0]         perim_reg;
    logic                last_reg;
    rpvg_pkg::crd_ctl_t  ctl_reg;
    logic signed [W-1:0] opx_reg, opy_reg;
    logic [31:0]         opa_reg;
    logic                tvalid_reg, tlast_reg, tuser_reg;
    logic [OUT_W-1:0]    tdata_reg;

    logic                crd_done;
    logic signed [W-1:0] crd_x, crd_y;
    logic signed [W-1:0] nx, ny, satx, saty;
    logic [SW-1:0]       psum;
    logic [39:0]         perim_next;
    logic                is_deg, at_end, ofree;

    rpvg_cordic #(.W(W), .STEPS(STEPS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl_reg),
        .in_x    (opx_reg),
        .in_y    (opy_reg),
        .in_ang  (opa_reg),
        .done    (crd_done),
        .out_x   (crd_x),
        .out_y   (crd_y)
    );

    assign job_ready = (state_reg == B_IDLE);
    assign m_tvalid  = tvalid_reg;
    assign m_tdata   = tdata_reg;
    assign m_tuser   = tuser_reg;
    assign m_tlast   = tlast_reg;
    assign ofree     = !tvalid_reg || m_tready;

    // vertex position and end-of-polygon test
    assign nx     = cx_reg + crd_x;
    assign ny     = cy_reg + crd_y;
    assign at_end = ({1'b0, idx_reg} == (n_reg - 7'd1));
    assign is_deg = crd_x[W-1] || (crd_x[W-2:0] < (W-1)'(min_radius));

    // saturating perimeter sum
    always_comb begin
        psum = SW'(perim_reg) + (crd_x[W-1] ? SW'(0) : SW'($unsigned(crd_x)));
        perim_next = (psum > SW'(rpvg_pkg::PERIM_MAX)) ? rpvg_pkg::PERIM_MAX : psum[39:0];
    end

    // output saturation to the coordinate range
    always_comb begin
        if (curx_reg > CMAX) satx = CMAX;
        else if (curx_reg < CMIN) satx = CMIN;
        else satx = curx_reg;
        if (cury_reg > CMAX) saty = CMAX;
        else if (cury_reg < CMIN) saty = CMIN;
        else saty = cury_reg;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
        end else if (ofree && (state_reg == B_EMIT || state_reg == B_DEG)) begin
            tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ofree && state_reg == B_EMIT) begin
            tdata_reg <= OUT_W'({(last_reg ? perim_reg : 40'd0), idx_reg,
                                 saty[CW-1:0], satx[CW-1:0]});
            tuser_reg <= 1'b0;
            tlast_reg <= last_reg;
        end else if (ofree && state_reg == B_DEG) begin
            tdata_reg <= OUT_W'({40'd0, 6'd0, cy_reg[CW-1:0], cx_reg[CW-1:0]});
            tuser_reg <= 1'b1;
            tlast_reg <= 1'b1;
        end
    end

    // vertex sequencer around the shared cordic unit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            ctl_reg   <= '0;
        end else begin
            case (state_reg)
                B_IDLE: begin
                    ctl_reg.start <= job_valid;
                    if (job_valid) begin
                        cx_reg         <= W'(signed'(job_cx));
                        cy_reg         <= W'(signed'(job_cy));
                        dx_reg         <= job_dx;
                        dy_reg         <= job_dy;
                        n_reg          <= job_n;
                        step_reg       <= job_step;
                        opx_reg        <= job_dx;
                        opy_reg        <= job_dy;
                        ctl_reg.rotate <= 1'b0;
                        state_reg      <= B_MAG;
                    end
                end
                B_MAG: begin
                    ctl_reg.start <= crd_done && !is_deg;
                    if (crd_done) begin
                        if (is_deg) begin
                            state_reg <= B_DEG;
                        end else begin
                            ang_reg        <= 32'd0;
                            idx_reg        <= 6'd0;
                            perim_reg      <= 40'd0;
                            opx_reg        <= dx_reg;
                            opy_reg        <= dy_reg;
                            opa_reg        <= 32'd0;
                            ctl_reg.rotate <= 1'b1;
                            state_reg      <= B_ROT;
                        end
                    end
                end
                B_ROT: begin
                    ctl_reg.start <= crd_done && (idx_reg != 6'd0);
                    if (crd_done) begin
                        curx_reg <= nx;
                        cury_reg <= ny;
                        last_reg <= 1'b0;
                        if (idx_reg == 6'd0) begin
                            p0x_reg   <= nx;
                            p0y_reg   <= ny;
                            state_reg <= B_EMIT;
                        end else begin
                            opx_reg        <= nx - prvx_reg;
                            opy_reg        <= ny - prvy_reg;
                            ctl_reg.rotate <= 1'b0;
                            state_reg      <= B_EDGE;
                        end
                    end
                end
                B_EDGE: begin
                    ctl_reg.start <= crd_done && at_end;
                    if (crd_done) begin
                        perim_reg <= perim_next;
                        if (at_end) begin
                            opx_reg        <= p0x_reg - curx_reg;
                            opy_reg        <= p0y_reg - cury_reg;
                            ctl_reg.rotate <= 1'b0;
                            state_reg      <= B_WRAP;
                        end else begin
                            state_reg <= B_EMIT;
                        end
                    end
                end
                B_WRAP: begin
                    ctl_reg.start <= 1'b0;
                    if (crd_done) begin
                        perim_reg <= perim_next;
                        last_reg  <= 1'b1;
                        state_reg <= B_EMIT;
                    end
                end
                B_EMIT: begin
                    ctl_reg.start <= ofree && !last_reg;
                    if (ofree) begin
                        prvx_reg <= curx_reg;
                        prvy_reg <= cury_reg;
                        if (last_reg) begin
                            state_reg <= B_IDLE;
                        end else begin
                            idx_reg        <= idx_reg + 6'd1;
                            ang_reg        <= ang_reg + step_reg;
                            opx_reg        <= dx_reg;
                            opy_reg        <= dy_reg;
                            opa_reg        <= ang_reg + step_reg;
                            ctl_reg.rotate <= 1'b1;
                            state_reg      <= B_ROT;
                        end
                    end
                end
                B_DEG: begin
                    ctl_reg.start <= 1'b0;
                    if (ofree) state_reg <= B_IDLE;
                end
                default: begin
                    ctl_reg.start <= 1'b0;
                    state_reg     <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/core/regular_polygon_vertex_generator.sv =====
`timescale 1ns / 1ps
// Regular polygon vertex generator: each request gives a center, a first
// vertex and a side count (clamped to 3..MAX_SIDES); the block streams one
// result per vertex, rotated by CORDIC in Q16.16, with the saturated
// perimeter on the last one, or a single degenerate result when the radius
// is below min_radius. One shared CORDIC unit in the back end sets the rate:
// an item needs 2*n+1 passes through it, and a degenerate item needs one. The
// front end takes the next request and works out its step angle with a
// divider while the back end is busy.
module regular_polygon_vertex_generator #(
    parameter int MAX_SIDES    = 64,
    parameter int COORD_WIDTH  = 32,
    parameter int CORDIC_STEPS = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // center_x, center_y, vertex_x, vertex_y, sides
    input  logic [((4 * COORD_WIDTH + 14) / 8) * 8 - 1:0] s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // point_x, point_y, vertex_number, perimeter
    output logic [((2 * COORD_WIDTH + 53) / 8) * 8 - 1:0] m_tdata,
    // degenerate
    output logic [0:0]             m_tuser,
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [30:0]            cfg_data
);

    localparam int CW    = COORD_WIDTH;
    localparam int W     = ((COORD_WIDTH > 24) ? COORD_WIDTH : 24) + 16;
    localparam int IN_W  = ((4 * COORD_WIDTH + 7 + 7) / 8) * 8;
    localparam int OUT_W = ((2 * COORD_WIDTH + 46 + 7) / 8) * 8;
    localparam int JW    = 2 * CW + 2 * W + 7 + 32;

    logic [30:0]   min_radius_reg;
    logic          f_valid, f_ready, b_valid, b_ready;
    logic [CW-1:0] f_cx, f_cy;
    logic [W-1:0]  f_dx, f_dy;
    logic [6:0]    f_n;
    logic [31:0]   f_step;
    logic [JW-1:0] b_job;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) min_radius_reg <= 31'd1;
        else if (cfg_valid) min_radius_reg <= cfg_data;
    end

    rpvg_front #(.CW(CW), .W(W), .IN_W(IN_W), .MAX_SIDES(MAX_SIDES)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job_cx    (f_cx),
        .job_cy    (f_cy),
        .job_dx    (f_dx),
        .job_dy    (f_dy),
        .job_n     (f_n),
        .job_step  (f_step)
    );

    rpvg_fifo #(.WIDTH(JW)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  ({f_step, f_n, f_dy, f_dx, f_cy, f_cx}),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_job)
    );

    rpvg_back #(.CW(CW), .W(W), .OUT_W(OUT_W), .STEPS(CORDIC_STEPS)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .job_valid  (b_valid),
        .job_ready  (b_ready),
        .job_cx     (b_job[CW-1:0]),
        .job_cy     (b_job[2*CW-1:CW]),
        .job_dx     (b_job[2*CW+W-1:2*CW]),
        .job_dy     (b_job[2*CW+2*W-1:2*CW+W]),
        .job_n      (b_job[2*CW+2*W+6:2*CW+2*W]),
        .job_step   (b_job[JW-1:2*CW+2*W+7]),
        .min_radius (min_radius_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
